// ----- sv/lidar_scan_point_clustering_assert.svh -----
// Assertion macros for the lidar scan point clustering checker.
// Used by lspc_checker; no other dependencies.
`ifndef LIDAR_SCAN_POINT_CLUSTERING_ASSERT_SVH
`define LIDAR_SCAN_POINT_CLUSTERING_ASSERT_SVH
// Check a property on every clock edge outside reset.
`define LSPC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check an implication on every clock edge outside reset.
`define LSPC_IMPLY(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`endif

// ----- sv/lspc_pkg.sv -----
// Shared types, constants and tables for the lidar scan point clustering block.
// No dependencies.
`default_nettype none
package lspc_pkg;
	localparam int RANGE_BITS = 16;
	localparam int MAX_CLUSTERS = 255;
	localparam int CLUSTER_CAP = (MAX_CLUSTERS < 255) ? MAX_CLUSTERS : 255;
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W = 4;
	localparam int ACC_W = 36;
	localparam int Z_W = 26;
	localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
	localparam int COORD_LIMIT = 65535;

	localparam logic [2:0] REG_ANGLE_START = 3'd0;
	localparam logic [2:0] REG_ANGLE_STEP  = 3'd1;
	localparam logic [2:0] REG_CUT_X       = 3'd2;
	localparam logic [2:0] REG_CUT_Y       = 3'd3;
	localparam logic [2:0] REG_JOIN_DIST   = 3'd4;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ROTATE,
		BK_CLASSIFY,
		BK_OUTPUT
	} bk_state_t;

	typedef struct packed {
		logic [RANGE_BITS-1:0] range;
		logic [15:0]           angle;
		logic                  scan_start;
	} job_t;

	function automatic logic [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
		logic [Z_W-1:0] v;
		case (i)
			4'd0: v = 26'd2097152;
			4'd1: v = 26'd1238021;
			4'd2: v = 26'd654136;
			4'd3: v = 26'd332050;
			4'd4: v = 26'd166669;
			4'd5: v = 26'd83416;
			4'd6: v = 26'd41718;
			4'd7: v = 26'd20860;
			4'd8: v = 26'd10430;
			4'd9: v = 26'd5215;
			4'd10: v = 26'd2608;
			4'd11: v = 26'd1304;
			4'd12: v = 26'd652;
			4'd13: v = 26'd326;
			4'd14: v = 26'd163;
			4'd15: v = 26'd81;
			default: v = '0;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

// ----- sv/lspc_if.sv -----
// Valid/ready channel interfaces for the lidar scan point clustering block.
// No dependencies.
`default_nettype none
interface lspc_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] range_mm;
	logic        scan_start;
	modport source (output valid, range_mm, scan_start, input ready);
	modport sink (input valid, range_mm, scan_start, output ready);
endinterface

interface lspc_out_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] x_mm;
	logic signed [16:0] y_mm;
	logic [7:0]         cluster_index;
	logic               in_area;
	logic               opens_cluster;
	modport source (output valid, x_mm, y_mm, cluster_index, in_area, opens_cluster,
		input ready);
	modport sink (input valid, x_mm, y_mm, cluster_index, in_area, opens_cluster,
		output ready);
endinterface

interface lspc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- sv/lidar_scan_point_clustering.sv -----
// Top level of the lidar scan point clustering block.
// Depends on lspc_pkg, lspc_if, lspc_front and lspc_back.
// Each range sample becomes one result: x/y in mm, a window flag and a cluster
// index. Back end: load, 16 CORDIC iterations on one shared shift-add unit,
// scale, window test and cluster update; the CORDIC loop sets the rate unless
// the output stalls. A two-entry queue lets the front accept samples while the
// back end works or its result waits. Configuration must be written while
// idle; the block itself does not enforce this.
`default_nettype none
module lidar_scan_point_clustering (
	input wire clk,
	input wire arst_n,
	lspc_in_if.sink    in_ch,
	lspc_out_if.source out_ch,
	lspc_cfg_if.sink   cfg
);
	import lspc_pkg::*;

	logic [15:0] angle_start_q, angle_step_q, cut_x_q, cut_y_q, join_q;
	logic job_valid, pop;
	job_t job;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_start_q <= 16'd0;
			angle_step_q <= 16'd46;
			cut_x_q <= 16'd500;
			cut_y_q <= 16'd500;
			join_q <= 16'd50;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ANGLE_START: angle_start_q <= cfg.data;
				REG_ANGLE_STEP: angle_step_q <= cfg.data;
				REG_CUT_X: cut_x_q <= cfg.data;
				REG_CUT_Y: cut_y_q <= cfg.data;
				REG_JOIN_DIST: join_q <= cfg.data;
				default: ;
			endcase
		end
	end

	lspc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.range_mm(in_ch.range_mm), .scan_start(in_ch.scan_start),
		.angle_start(angle_start_q), .angle_step(angle_step_q),
		.pop(pop), .job_valid(job_valid), .job(job)
	);

	lspc_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(job_valid), .job(job), .pop(pop),
		.cut_x(cut_x_q), .cut_y(cut_y_q), .join_distance(join_q),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.x_mm(out_ch.x_mm), .y_mm(out_ch.y_mm),
		.cluster_index(out_ch.cluster_index), .in_area(out_ch.in_area),
		.opens_cluster(out_ch.opens_cluster)
	);
endmodule
`default_nettype wire

// ----- sv/lspc_front.sv -----
// Front end: accepts samples, tracks beam angle, pushes jobs into a 2-entry queue.
// Depends on lspc_pkg.
`default_nettype none
module lspc_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  [15:0]         range_mm,
	input  wire                 scan_start,
	input  wire  [15:0]         angle_start,
	input  wire  [15:0]         angle_step,
	input  wire                 pop,
	output logic                job_valid,
	output lspc_pkg::job_t      job
);
	import lspc_pkg::*;

	job_t       fifo_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic [15:0] angle_q;
	logic [15:0] cur_angle;
	logic push;

	assign in_ready  = (count_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign job_valid = (count_q != 2'd0);
	assign job       = fifo_q[rd_ptr_q];
	assign cur_angle = scan_start ? angle_start : angle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				angle_q <= cur_angle + angle_step;
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop && job_valid) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop && job_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q].range      <= range_mm[RANGE_BITS-1:0];
			fifo_q[wr_ptr_q].angle      <= cur_angle;
			fifo_q[wr_ptr_q].scan_start <= scan_start;
		end
	end
endmodule
`default_nettype wire

// ----- sv/lspc_back.sv -----
// Back end: iterative CORDIC rotation, window test and cluster tracking.
// Depends on lspc_pkg.
`default_nettype none
module lspc_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 job_valid,
	input  wire lspc_pkg::job_t job,
	output logic                pop,
	input  wire  [15:0]         cut_x,
	input  wire  [15:0]         cut_y,
	input  wire  [15:0]         join_distance,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic signed [16:0]  x_mm,
	output logic signed [16:0]  y_mm,
	output logic [7:0]          cluster_index,
	output logic                in_area,
	output logic                opens_cluster
);
	import lspc_pkg::*;

	bk_state_t state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic signed [ACC_W-1:0] cx_q, cy_q;
	logic signed [Z_W-1:0]   z_q;
	logic [1:0] quad_q;
	logic scan_q;
	logic signed [16:0] last_x_q, last_y_q;
	logic [7:0] cur_q;
	logic signed [16:0] px_q, py_q;
	logic [7:0] ocl_q;
	logic oin_q, oopen_q;

	logic signed [ACC_W-1:0] dx, dy, rx, ry;
	logic signed [16:0] mx, my, bx, by;
	logic signed [17:0] ddx, ddy;
	logic [31:0] j2;
	logic in_win;
	logic [7:0] base_cl;
	logic issue, done_out;

	function automatic logic signed [16:0] to_mm(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		r = (v + ACC_W'(32768)) >>> 16;
		if (r > ACC_W'(COORD_LIMIT)) return 17'sd65535;
		if (r < -ACC_W'(COORD_LIMIT)) return -17'sd65535;
		return r[16:0];
	endfunction

	assign dx = cy_q >>> step_q;
	assign dy = cx_q >>> step_q;

	always_comb begin
		case (quad_q)
			2'd0: begin rx = cx_q; ry = cy_q; end
			2'd1: begin rx = -cy_q; ry = cx_q; end
			2'd2: begin rx = -cx_q; ry = -cy_q; end
			default: begin rx = cy_q; ry = -cx_q; end
		endcase
	end
	assign mx = to_mm(rx);
	assign my = to_mm(ry);
	assign bx = scan_q ? 17'sd0 : last_x_q;
	assign by = scan_q ? 17'sd0 : last_y_q;
	assign base_cl = scan_q ? 8'd0 : cur_q;
	assign in_win = !(px_q > $signed({1'b0, cut_x}) || px_q < -$signed({1'b0, cut_x})
		|| py_q > $signed({1'b0, cut_y}) || py_q < -$signed({1'b0, cut_y}));
	assign ddx = 18'(px_q) - 18'(bx);
	assign ddy = 18'(py_q) - 18'(by);
	assign j2 = join_distance * join_distance;

	assign issue = (state_q == BK_IDLE) && job_valid;
	assign done_out = out_valid && out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: if (job_valid) state_d = BK_ROTATE;
			BK_ROTATE: if (step_q == STEP_W'(CORDIC_STEPS-1)) state_d = BK_CLASSIFY;
			BK_CLASSIFY: if (!out_valid || out_ready) state_d = BK_OUTPUT;
			BK_OUTPUT: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop = issue;
	end

	logic signed [35:0] sq_x_s1, sq_y_s1;
	always_comb begin
		sq_x_s1 = ddx * ddx;
		sq_y_s1 = ddy * ddy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			step_q <= '0;
			out_valid <= 1'b0;
			cur_q <= '0;
			last_x_q <= '0;
			last_y_q <= '0;
		end else begin
			state_q <= state_d;
			if (done_out) out_valid <= 1'b0;
			case (state_q)
				BK_ROTATE: step_q <= step_q + 1'b1;
				BK_OUTPUT: begin
					out_valid <= 1'b1;
					if (!in_win) begin
						cur_q <= base_cl;
						if (base_cl == 8'd0) begin
							last_x_q <= '0;
							last_y_q <= '0;
						end else begin
							last_x_q <= bx;
							last_y_q <= by;
						end
					end else begin
						if ((sq_x_s1 + sq_y_s1) >= 36'(j2))
							cur_q <= (base_cl < 8'(CLUSTER_CAP)) ? base_cl + 1'b1 : base_cl;
						else cur_q <= base_cl;
						last_x_q <= px_q;
						last_y_q <= py_q;
					end
				end
				default: step_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				cx_q <= ACC_W'(job.range) * ACC_W'(INV_GAIN_Q16);
				cy_q <= '0;
				z_q <= Z_W'({job.angle[13:0], 8'd0});
				quad_q <= job.angle[15:14];
				scan_q <= job.scan_start;
			end
			BK_ROTATE: begin
				if (!z_q[Z_W-1]) begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					z_q <= z_q - atan_entry(step_q);
				end else begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					z_q <= z_q + atan_entry(step_q);
				end
			end
			BK_CLASSIFY: begin
				px_q <= mx;
				py_q <= my;
			end
			BK_OUTPUT: begin
				oin_q <= in_win;
				if (in_win) begin
					oopen_q <= (sq_x_s1 + sq_y_s1) >= 36'(j2);
					if ((sq_x_s1 + sq_y_s1) >= 36'(j2))
						ocl_q <= (base_cl < 8'(CLUSTER_CAP)) ? base_cl + 1'b1 : base_cl;
					else ocl_q <= base_cl;
				end else begin
					oopen_q <= 1'b0;
					ocl_q <= 8'd0;
				end
				x_mm <= px_q;
				y_mm <= py_q;
			end
			default: ;
		endcase
	end

	assign cluster_index = ocl_q;
	assign in_area = oin_q;
	assign opens_cluster = oopen_q;
endmodule
`default_nettype wire

// ----- sv/lspc_checker.sv -----
// Port-level checker for the lidar scan point clustering block, with its bind.
// Depends on lidar_scan_point_clustering_assert.svh.
`default_nettype none
`include "lidar_scan_point_clustering_assert.svh"
module lspc_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               out_valid,
	input wire               out_ready,
	input wire [7:0]         cluster_index,
	input wire               in_area,
	input wire               opens_cluster
);
	`LSPC_IMPLY(a_out_idx, clk, arst_n, out_valid && !in_area, cluster_index == 8'd0, "out-of-area point has cluster")
	`LSPC_IMPLY(a_out_open, clk, arst_n, out_valid && !in_area, !opens_cluster, "out-of-area point opens cluster")
	`LSPC_IMPLY(a_open_nz, clk, arst_n, out_valid && opens_cluster, cluster_index != 8'd0, "opened cluster zero")
	`LSPC_IMPLY(a_hold, clk, arst_n, out_valid && !out_ready, ##1 out_valid, "result dropped")
endmodule

bind lidar_scan_point_clustering lspc_checker u_checker (
	.clk(clk), .arst_n(arst_n),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.cluster_index(out_ch.cluster_index), .in_area(out_ch.in_area),
	.opens_cluster(out_ch.opens_cluster)
);
`default_nettype wire
